// ----- sv/mme_pkg.sv -----
// ----------------------------------------------------------------------------
// mme_pkg
// Shared types and constants of the matrix multiply engine: item and result
// beats, function and register codes, and the controller/datapath command.
// ----------------------------------------------------------------------------
package mme_pkg;

  localparam int MAX_DIM_DEF = 8;
  localparam int FRAC_BITS   = 12;

  localparam int IDX_W  = 3;
  localparam int VAL_W  = 16;
  localparam int CFG_W  = 4;
  localparam int CIDX_W = 2;
  localparam int PROD_W = 2 * VAL_W;
  localparam int ACC_W  = 40;

  localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

  typedef enum logic [1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_COMPUTE = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  localparam logic [CIDX_W-1:0] CFG_ROWS_A    = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_INNER_DIM = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_COLS_B    = 2'd2;

  typedef struct packed {
    func_t                   func;
    logic [IDX_W-1:0]        row_index;
    logic [IDX_W-1:0]        col_index;
    logic signed [VAL_W-1:0] element_value;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [VAL_W-1:0] out_value;
    logic                    saturated;
    logic                    last;
  } result_t;

  typedef struct packed {
    logic a;
    logic b;
  } wr_t;

  typedef struct packed {
    logic             valid;
    logic             zero;
    logic             first;
    logic             last_k;
    logic             last;
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } cmd_t;

  typedef struct packed {
    logic active;
  } status_t;

endpackage

// ----- sv/mme_ctrl.sv -----
// ----------------------------------------------------------------------------
// mme_ctrl
// Controller: holds the dimension registers, decodes items and steps the
// row/column/inner indices of a compute run, one multiply beat per cycle.
// ----------------------------------------------------------------------------
module mme_ctrl
  import mme_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  func_t             func,
  output logic              busy,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  output wr_t               wr,
  output cmd_t              cmd,
  input  status_t           stat
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN
  } state_t;

  localparam logic [CFG_W-1:0] MAX_D = CFG_W'(MAX_DIM);

  state_t           state;
  logic [CFG_W-1:0] rows_a;
  logic [CFG_W-1:0] inner_dim;
  logic [CFG_W-1:0] cols_b;
  logic [IDX_W-1:0] i;
  logic [IDX_W-1:0] j;
  logic [IDX_W-1:0] k;

  logic [CFG_W-1:0] m_eff;
  logic [CFG_W-1:0] n_eff;
  logic [CFG_W-1:0] p_eff;
  logic             accept;
  logic             last_k;
  logic             last_j;
  logic             last_i;

  assign m_eff = (rows_a > MAX_D) ? MAX_D : rows_a;
  assign n_eff = (inner_dim > MAX_D) ? MAX_D : inner_dim;
  assign p_eff = (cols_b > MAX_D) ? MAX_D : cols_b;

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign wr.a = accept && (func == FUNC_LOAD_A);
  assign wr.b = accept && (func == FUNC_LOAD_B);

  assign last_k = (n_eff == '0) || (CFG_W'(k) == n_eff - 4'd1);
  assign last_j = (CFG_W'(j) == p_eff - 4'd1);
  assign last_i = (CFG_W'(i) == m_eff - 4'd1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rows_a    <= DIM_RESET;
      inner_dim <= DIM_RESET;
      cols_b    <= DIM_RESET;
      i         <= '0;
      j         <= '0;
      k         <= '0;
      cmd       <= '0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ROWS_A:    rows_a    <= cfg_data;
          CFG_INNER_DIM: inner_dim <= cfg_data;
          CFG_COLS_B:    cols_b    <= cfg_data;
          default: ;
        endcase
      end
      unique case (state)
        ST_IDLE: begin
          cmd.valid <= 1'b0;
          if (accept && (func == FUNC_COMPUTE) && (m_eff != '0) && (p_eff != '0)) begin
            i     <= '0;
            j     <= '0;
            k     <= '0;
            state <= ST_RUN;
          end
        end
        ST_RUN: begin
          cmd.valid  <= 1'b1;
          cmd.zero   <= (n_eff == '0);
          cmd.first  <= (k == '0);
          cmd.last_k <= last_k;
          cmd.last   <= last_k && last_j && last_i;
          cmd.i      <= i;
          cmd.j      <= j;
          cmd.k      <= k;
          if (!last_k) begin
            k <= k + 3'd1;
          end else begin
            k <= '0;
            if (last_j) begin
              j <= '0;
              i <= i + 3'd1;
              if (last_i) begin
                state <= ST_DRAIN;
              end
            end else begin
              j <= j + 3'd1;
            end
          end
        end
        ST_DRAIN: begin
          cmd.valid <= 1'b0;
          if (!cmd.valid && !stat.active) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ----- sv/mme_datapath.sv -----
// ----------------------------------------------------------------------------
// mme_datapath
// Datapath: A and B element memories, registered read, multiplier stage,
// 40-bit accumulator, and the round/saturate output register.
// ----------------------------------------------------------------------------
module mme_datapath
  import mme_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  item_t   item,
  input  wr_t     wr,
  input  cmd_t    cmd,
  output status_t stat,
  output logic    result_valid,
  output result_t result
);

  localparam int DEPTH  = MAX_DIM * MAX_DIM;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic signed [ACC_W-1:0] RND_HALF =
    (FRAC_BITS > 0) ? ACC_W'(1) <<< ((FRAC_BITS > 0) ? FRAC_BITS - 1 : 0) : '0;
  localparam logic signed [ACC_W-1:0] SAT_MAX = ACC_W'(32767);
  localparam logic signed [ACC_W-1:0] SAT_MIN = -ACC_W'(32768);

  logic [VAL_W-1:0] a_mem [DEPTH];
  logic [VAL_W-1:0] b_mem [DEPTH];

  logic                     in_range;
  logic [ADDR_W-1:0]        wr_addr;
  logic [ADDR_W-1:0]        a_addr;
  logic [ADDR_W-1:0]        b_addr;

  cmd_t                     s1;
  cmd_t                     s2;
  cmd_t                     s3;
  cmd_t                     s3_next;
  logic signed [VAL_W-1:0]  a_rd;
  logic signed [VAL_W-1:0]  b_rd;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  logic signed [ACC_W-1:0]  rounded;
  logic signed [ACC_W-1:0]  shifted;

  assign in_range = (int'(item.row_index) < MAX_DIM) && (int'(item.col_index) < MAX_DIM);
  assign wr_addr  = ADDR_W'(int'(item.row_index) * MAX_DIM + int'(item.col_index));
  assign a_addr   = ADDR_W'(int'(cmd.i) * MAX_DIM + int'(cmd.k));
  assign b_addr   = ADDR_W'(int'(cmd.k) * MAX_DIM + int'(cmd.j));

  always_ff @(posedge clk) begin
    if (wr.a && in_range) begin
      a_mem[wr_addr] <= item.element_value;
    end
    if (wr.b && in_range) begin
      b_mem[wr_addr] <= item.element_value;
    end
    if (cmd.valid) begin
      a_rd <= a_mem[a_addr];
      b_rd <= b_mem[b_addr];
    end
  end

  always_comb begin
    s3_next       = s2;
    s3_next.valid = s2.valid && s2.last_k;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1  <= '0;
      s2  <= '0;
      s3  <= '0;
      acc <= '0;
    end else begin
      s1 <= cmd;
      s2 <= s1;
      s3 <= s3_next;
      if (s2.valid) begin
        acc <= s2.first ? ACC_W'(prod) : acc + ACC_W'(prod);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1.valid) begin
      if (s1.zero) begin
        prod <= '0;
      end else begin
        prod <= a_rd * b_rd;
      end
    end
  end

  assign rounded = acc + RND_HALF;
  assign shifted = rounded >>> FRAC_BITS;

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= s3.valid;
    end
    if (s3.valid) begin
      result.out_row <= s3.i;
      result.out_col <= s3.j;
      result.last    <= s3.last;
      if (shifted > SAT_MAX) begin
        result.out_value <= VAL_W'(SAT_MAX);
        result.saturated <= 1'b1;
      end else if (shifted < SAT_MIN) begin
        result.out_value <= VAL_W'(SAT_MIN);
        result.saturated <= 1'b1;
      end else begin
        result.out_value <= VAL_W'(shifted);
        result.saturated <= 1'b0;
      end
    end
  end

  assign stat.active = s1.valid || s2.valid || s3.valid || result_valid;

endmodule

// ----- sv/matrix_multiply_engine.sv -----
// ----------------------------------------------------------------------------
// matrix_multiply_engine
// Signed Q4.12 matrix multiply C = A x B with rounding and saturation.
// ----------------------------------------------------------------------------
// Items enter on start/item and are taken when start is high and busy is low.
// A load item (load A or load B) writes one element in the accepting cycle;
// busy stays low, so loads go at one beat per cycle. Positions outside the
// matrix are dropped.
// A compute item with nonzero rows and columns raises busy and streams one
// multiply-accumulate per cycle through memory read, multiplier, accumulator
// and output register; busy falls once the pipeline has drained. The
// dimensions rows_a, inner_dim and cols_b are clamped to MAX_DIM, and an
// inner dimension of zero gives one zero product per result.
// Results come out in row order, one beat per cycle of result_valid, and the
// final beat of the run has last set. The receiver cannot stall: take every
// beat in the cycle it is shown. Zero rows or columns gives no results.
// Registers are written over cfg_valid/cfg_ready (always ready); write them
// only while idle, as the block does not enforce it. Reset sets all three
// dimensions to 8 and clears control; the element memories hold no reset
// value and must be loaded before use.
// ----------------------------------------------------------------------------
module matrix_multiply_engine
  import mme_pkg::*;
#(
  parameter int MAX_DIM = MAX_DIM_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  item_t             item,
  output logic              result_valid,
  output result_t           result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CIDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  wr_t     wr;
  cmd_t    cmd;
  status_t stat;

  mme_ctrl #(
    .MAX_DIM(MAX_DIM)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .func     (item.func),
    .busy     (busy),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .wr       (wr),
    .cmd      (cmd),
    .stat     (stat)
  );

  mme_datapath #(
    .MAX_DIM(MAX_DIM)
  ) u_datapath (
    .clk         (clk),
    .rst         (rst),
    .item        (item),
    .wr          (wr),
    .cmd         (cmd),
    .stat        (stat),
    .result_valid(result_valid),
    .result      (result)
  );

endmodule

// ----- tb/matrix_multiply_engine_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix_multiply_engine_test
// Self-checking bench for the Q4.12 matrix multiply engine. A and B elements
// are loaded, products are run under many dimension settings, and every C
// beat is checked against an in-bench fixed-point model of the sum of
// products, half-LSB rounding and saturation.
// ----------------------------------------------------------------------------
module matrix_multiply_engine_test;
  import mme_pkg::*;

  localparam int     DIM        = MAX_DIM_DEF;
  localparam int     TAIL       = 10;
  localparam int     IDLE_LIMIT = 2000;
  localparam int     RAND_ITEMS = 120;
  localparam longint VMAX       = 32767;
  localparam longint VMIN       = -32768;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  logic              busy;
  item_t             item      = '0;
  logic              result_valid;
  result_t           result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [CIDX_W-1:0] cfg_index = CFG_ROWS_A;
  logic [CFG_W-1:0]  cfg_data  = '0;

  matrix_multiply_engine uut (.*);

  always #5 clk = ~clk;

  logic signed [VAL_W-1:0] a_elem [DIM*DIM];
  logic signed [VAL_W-1:0] b_elem [DIM*DIM];
  logic [CFG_W-1:0]        rows_reg  = DIM_RESET;
  logic [CFG_W-1:0]        inner_reg = DIM_RESET;
  logic [CFG_W-1:0]        cols_reg  = DIM_RESET;
  result_t                 c_expect [$];

  bit a_loaded [DIM*DIM];
  bit b_loaded [DIM*DIM];
  int m_dim = DIM;
  int n_dim = DIM;
  int p_dim = DIM;
  int errors = 0;
  int items_taken = 0;
  int products = 0;
  int beats_checked = 0;
  int burst_left = 0;
  int idle_cycles = 0;

  function automatic int clamp_dim(logic [CFG_W-1:0] r);
    return (r > DIM) ? DIM : int'(r);
  endfunction

  function automatic void model_item(item_t it);
    int      m, n, p;
    longint  acc, q;
    result_t r;
    case (it.func)
      FUNC_LOAD_A: a_elem[it.row_index * DIM + it.col_index] = it.element_value;
      FUNC_LOAD_B: b_elem[it.row_index * DIM + it.col_index] = it.element_value;
      FUNC_COMPUTE: begin
        m = clamp_dim(rows_reg);
        n = clamp_dim(inner_reg);
        p = clamp_dim(cols_reg);
        for (int i = 0; i < m; i++) begin
          for (int j = 0; j < p; j++) begin
            acc = 0;
            for (int k = 0; k < n; k++)
              acc += longint'(a_elem[i * DIM + k]) * longint'(b_elem[k * DIM + j]);
            q = (acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
            r.saturated = 1'b0;
            if (q > VMAX) begin
              q = VMAX;
              r.saturated = 1'b1;
            end else if (q < VMIN) begin
              q = VMIN;
              r.saturated = 1'b1;
            end
            r.out_row   = IDX_W'(i);
            r.out_col   = IDX_W'(j);
            r.out_value = q[VAL_W-1:0];
            r.last      = (i == m - 1) && (j == p - 1);
            c_expect.push_back(r);
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    if (!rst && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ROWS_A:    rows_reg  = cfg_data;
        CFG_INNER_DIM: inner_reg = cfg_data;
        CFG_COLS_B:    cols_reg  = cfg_data;
        default: ;
      endcase
    end
    if (!rst && start && !busy) begin
      items_taken++;
      if (item.func == FUNC_COMPUTE)
        products++;
      model_item(item);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_valid) begin
      if (c_expect.size() == 0) begin
        $error("unexpected result beat: row %0d col %0d value %0d",
               result.out_row, result.out_col, result.out_value);
        errors++;
      end else begin
        want = c_expect.pop_front();
        beats_checked++;
        if (result.out_row !== want.out_row) begin
          $error("out_row: expected %0d, got %0d", want.out_row, result.out_row);
          errors++;
        end
        if (result.out_col !== want.out_col) begin
          $error("out_col: expected %0d, got %0d", want.out_col, result.out_col);
          errors++;
        end
        if (result.out_value !== want.out_value) begin
          $error("out_value: expected %0d, got %0d", want.out_value, result.out_value);
          errors++;
        end
        if (result.saturated !== want.saturated) begin
          $error("saturated: expected %0b, got %0b", want.saturated, result.saturated);
          errors++;
        end
        if (result.last !== want.last) begin
          $error("last: expected %0b, got %0b", want.last, result.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
      1, 2:    return VAL_W'($urandom);
      default: return VAL_W'($urandom_range(0, 16383) - 8192);
    endcase
  endfunction

  function automatic item_t rand_item(func_t f);
    item_t it;
    it.func          = f;
    it.row_index     = IDX_W'($urandom_range(0, DIM - 1));
    it.col_index     = IDX_W'($urandom_range(0, DIM - 1));
    it.element_value = rand_value();
    return it;
  endfunction

  function automatic logic [CFG_W-1:0] pick_dim();
    case ($urandom_range(0, 15))
      0:       return '0;
      1:       return CFG_W'($urandom_range(DIM, 15));
      2:       return CFG_W'(DIM);
      default: return CFG_W'($urandom_range(1, 4));
    endcase
  endfunction

  task automatic send_item(input item_t it);
    start <= 1'b1;
    item  <= it;
    do @(posedge clk); while (busy);
  endtask

  task automatic load_elem(input func_t f, input int r, input int c,
                           input logic [VAL_W-1:0] v);
    item_t it;
    it.func          = f;
    it.row_index     = IDX_W'(r);
    it.col_index     = IDX_W'(c);
    it.element_value = v;
    if (f == FUNC_LOAD_A)
      a_loaded[r * DIM + c] = 1'b1;
    else
      b_loaded[r * DIM + c] = 1'b1;
    send_item(it);
  endtask

  // burst pacing: a long run without gaps now and then
  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? 20 : $urandom_range(1, 8);
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (c_expect.size() != 0 || busy) @(posedge clk);
    repeat (TAIL) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CIDX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_dims(input logic [CFG_W-1:0] rows, input logic [CFG_W-1:0] inner,
                          input logic [CFG_W-1:0] cols);
    wait_idle();
    write_reg(CFG_ROWS_A, rows);
    write_reg(CFG_INNER_DIM, inner);
    write_reg(CFG_COLS_B, cols);
    cfg_valid <= 1'b0;
    m_dim = clamp_dim(rows);
    n_dim = clamp_dim(inner);
    p_dim = clamp_dim(cols);
  endtask

  // load every element the next product reads that has never been written
  task automatic fill_missing();
    for (int i = 0; i < m_dim; i++)
      for (int k = 0; k < n_dim; k++)
        if (!a_loaded[i * DIM + k]) begin
          load_elem(FUNC_LOAD_A, i, k, rand_value());
          pace();
        end
    for (int k = 0; k < n_dim; k++)
      for (int j = 0; j < p_dim; j++)
        if (!b_loaded[k * DIM + j]) begin
          load_elem(FUNC_LOAD_B, k, j, rand_value());
          pace();
        end
  endtask

  task automatic test_rounding_saturation();
    set_dims(1, 1, 4);
    load_elem(FUNC_LOAD_A, 0, 0, 16'h7FFF);
    load_elem(FUNC_LOAD_B, 0, 0, 16'h7FFF);
    load_elem(FUNC_LOAD_B, 0, 1, 16'h8000);
    load_elem(FUNC_LOAD_B, 0, 2, 16'h0800);
    load_elem(FUNC_LOAD_B, 0, 3, 16'h0001);
    send_item(rand_item(FUNC_COMPUTE));
    load_elem(FUNC_LOAD_A, 0, 0, 16'h8000);
    send_item(rand_item(FUNC_COMPUTE));
    // half-LSB ties and just below, both signs
    load_elem(FUNC_LOAD_A, 0, 0, 16'h0001);
    load_elem(FUNC_LOAD_B, 0, 0, 16'h0800);
    load_elem(FUNC_LOAD_B, 0, 1, 16'h07FF);
    load_elem(FUNC_LOAD_B, 0, 2, 16'hF800);
    load_elem(FUNC_LOAD_B, 0, 3, 16'hF7FF);
    send_item(rand_item(FUNC_COMPUTE));
  endtask

  task automatic test_dimension_edges();
    set_dims(0, 1, 1);
    send_item(rand_item(FUNC_COMPUTE));
    set_dims(1, 1, 0);
    send_item(rand_item(FUNC_COMPUTE));
    set_dims(2, 0, 3);
    send_item(rand_item(FUNC_COMPUTE));
    send_item(rand_item(FUNC_NONE));
    set_dims(1, 1, 1);
    send_item(rand_item(FUNC_COMPUTE));
  endtask

  task automatic test_random_phases();
    int goal, phase, quota;
    goal       = items_taken + RAND_ITEMS;
    phase      = 0;
    burst_left = 0;
    while (items_taken < goal) begin
      set_dims(pick_dim(), pick_dim(), pick_dim());
      quota = $urandom_range(10, 25);
      for (int s = 0; s < quota; s++) begin
        if (phase == 1 && s == quota / 2)
          wait_idle();
        case ($urandom_range(0, 15))
          0: send_item(rand_item(FUNC_NONE));
          1, 2: begin
            fill_missing();
            send_item(rand_item(FUNC_COMPUTE));
          end
          default: load_elem($urandom_range(0, 1) ? FUNC_LOAD_B : FUNC_LOAD_A,
                             $urandom_range(0, DIM - 1), $urandom_range(0, DIM - 1),
                             rand_value());
        endcase
        pace();
      end
      fill_missing();
      send_item(rand_item(FUNC_COMPUTE));
      pace();
      phase++;
    end
  endtask

  task automatic test_full_size();
    set_dims(15, 9, 8);
    fill_missing();
    send_item(rand_item(FUNC_COMPUTE));
    set_dims(8, 8, 8);
    send_item(rand_item(FUNC_COMPUTE));
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    test_rounding_saturation();
    test_dimension_edges();
    test_random_phases();
    test_full_size();
    wait_idle();
    $display("covered %0d items with %0d products, %0d result beats checked",
             items_taken, products, beats_checked);
    $display("dimensions from 0 to 15 per register, clamped 8x8x8, rounding ties, clipping");
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// ----- sim.f -----
sv/mme_pkg.sv
sv/mme_ctrl.sv
sv/mme_datapath.sv
sv/matrix_multiply_engine.sv
tb/matrix_multiply_engine_test.sv
